// ===== hdl/biquad_iir_filter_top_macros.svh =====
// ------------------------------------------------------------------------
// Biquad IIR filter assertion macros
// Shared concurrent assertion forms, clocked on i_clk, idle during reset.
// ------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_TOP_MACROS_SVH
`define BIQUAD_IIR_FILTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bq_pkg.sv =====
// ------------------------------------------------------------------------
// Biquad IIR filter package
// Widths, fixed-point constants, register codes, step controls and the
// state saturation function shared by the filter modules.
// ------------------------------------------------------------------------
package bq_pkg;

    // Basic sizes
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int ORDER    = 2;
    localparam int STATE_W  = 40;
    localparam int FRAC     = COEF_W - 3;

    // Number of feed-forward / feedback taps beyond tap 0 held in registers
    localparam int MAX_TAP  = 2;

    // Feedback product is split into a low (unsigned) and high (signed) half
    localparam int SPLIT    = STATE_W / 2;
    localparam int MUL_A_W  = (SAMPLE_W > SPLIT + 1) ? SAMPLE_W : SPLIT + 1;
    localparam int MUL_P_W  = MUL_A_W + COEF_W;
    localparam int XPROD_W  = SAMPLE_W + COEF_W;
    localparam int FBPROD_W = STATE_W + COEF_W;
    localparam int R_W      = FBPROD_W - FRAC;
    localparam int ACC_W    = ((XPROD_W > STATE_W) ? XPROD_W : STATE_W) + 1;
    localparam int SAT_IN_W = ((ACC_W > R_W) ? ACC_W : R_W) + 1;

    // Rounded output before saturation
    localparam int Y_W      = (((ACC_W + 1 - FRAC) > SAMPLE_W) ?
                               (ACC_W + 1 - FRAC) : SAMPLE_W) + 1;
    localparam int RND_W    = Y_W + FRAC;

    // Register map
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FF0,
        CFG_FF1,
        CFG_FF2,
        CFG_FB1,
        CFG_FB2
    } t_cfg_idx;

    // Unity gain in Q2.FRAC
    localparam logic signed [COEF_W-1:0] FF0_RESET = COEF_W'(1 << FRAC);

    // Output sample limits
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // One strobe per step of the per-sample sequence
    typedef struct packed {
        logic mul_x;
        logic acc;
        logic clamp;
        logic mul_lo;
        logic mul_hi;
        logic rnd;
        logic upd;
    } t_step;

    // Saturate a wide value to the delay state width
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic [SAT_IN_W-STATE_W:0] top;
        logic signed [STATE_W-1:0] s;
        top = v[SAT_IN_W-1:STATE_W-1];
        if ((&top) || !(|top)) begin
            s = v[STATE_W-1:0];
        end else begin
            s = {v[SAT_IN_W-1], {(STATE_W-1){~v[SAT_IN_W-1]}}};
        end
        return s;
    endfunction

endpackage

// ===== hdl/bq_cell.sv =====
// ------------------------------------------------------------------------
// Biquad delay cell
// One delay element of the transposed structure. Holds its state word,
// takes the neighbour's state, and updates to
// x*ff - round(fb*acc) + next using one shared multiplier over three steps.
// ------------------------------------------------------------------------
module bq_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bq_pkg::t_step                      i_step,
    input  logic signed [bq_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [bq_pkg::COEF_W-1:0]   i_ff,
    input  logic signed [bq_pkg::COEF_W-1:0]   i_fb,
    input  logic signed [bq_pkg::STATE_W-1:0]  i_accf,
    input  logic signed [bq_pkg::STATE_W-1:0]  i_next,
    output logic signed [bq_pkg::STATE_W-1:0]  o_state
);

    localparam logic signed [bq_pkg::FBPROD_W-1:0] HALF =
        bq_pkg::FBPROD_W'(1) <<< (bq_pkg::FRAC - 1);

    logic signed [bq_pkg::STATE_W-1:0]  r_state;
    logic signed [bq_pkg::MUL_P_W-1:0]  r_prod;
    logic signed [bq_pkg::MUL_P_W-1:0]  r_lo;
    logic signed [bq_pkg::ACC_W-1:0]    r_t;
    logic signed [bq_pkg::R_W-1:0]      r_r;

    logic signed [bq_pkg::MUL_A_W-1:0]  w_mul_a;
    logic signed [bq_pkg::COEF_W-1:0]   w_mul_b;
    logic signed [bq_pkg::MUL_P_W-1:0]  w_mul_p;
    logic signed [bq_pkg::FBPROD_W-1:0] w_fb_sum;
    logic signed [bq_pkg::SAT_IN_W-1:0] w_v;

    // Select multiplier operands for the current step
    always_comb begin
        if (i_step.mul_x) begin
            w_mul_a = bq_pkg::MUL_A_W'(i_x);
        end else if (i_step.mul_lo) begin
            w_mul_a = bq_pkg::MUL_A_W'($signed({1'b0, i_accf[bq_pkg::SPLIT-1:0]}));
        end else begin
            w_mul_a = bq_pkg::MUL_A_W'($signed(i_accf[bq_pkg::STATE_W-1:bq_pkg::SPLIT]));
        end
        w_mul_b = i_step.mul_x ? i_ff : i_fb;
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // Recombine the two feedback halves and add the rounding offset
    assign w_fb_sum = (bq_pkg::FBPROD_W'(r_prod) <<< bq_pkg::SPLIT)
                    + bq_pkg::FBPROD_W'(r_lo) + HALF;

    // New state before saturation
    assign w_v = bq_pkg::SAT_IN_W'(r_t) - bq_pkg::SAT_IN_W'(r_r);

    // Work registers of the datapath
    always_ff @(posedge i_clk) begin
        if (i_step.mul_x || i_step.mul_lo || i_step.mul_hi) begin
            r_prod <= w_mul_p;
        end
        if (i_step.mul_hi) begin
            r_lo <= r_prod;
        end
        if (i_step.acc) begin
            r_t <= bq_pkg::ACC_W'(r_prod) + bq_pkg::ACC_W'(i_next);
        end
        if (i_step.rnd) begin
            r_r <= bq_pkg::R_W'(w_fb_sum >>> bq_pkg::FRAC);
        end
    end

    // Hold the delay state, update once per sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step.upd) begin
            r_state <= bq_pkg::sat_state(w_v);
        end
    end

    assign o_state = r_state;

endmodule

// ===== hdl/bq_head.sv =====
// ------------------------------------------------------------------------
// Biquad output stage
// Forms acc = x*ff0 + s0, clamps it for the feedback path, and rounds and
// saturates it to the output sample with a clip flag.
// ------------------------------------------------------------------------
module bq_head (
    input  logic                               i_clk,
    input  bq_pkg::t_step                      i_step,
    input  logic signed [bq_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [bq_pkg::COEF_W-1:0]   i_ff0,
    input  logic signed [bq_pkg::STATE_W-1:0]  i_s0,
    output logic signed [bq_pkg::STATE_W-1:0]  o_accf,
    output logic signed [bq_pkg::SAMPLE_W-1:0] o_y,
    output logic                               o_clip
);

    localparam logic signed [bq_pkg::RND_W-1:0] HALF =
        bq_pkg::RND_W'(1) <<< (bq_pkg::FRAC - 1);

    logic signed [bq_pkg::XPROD_W-1:0]  r_prod;
    logic signed [bq_pkg::ACC_W-1:0]    r_acc;
    logic signed [bq_pkg::STATE_W-1:0]  r_accf;
    logic signed [bq_pkg::SAMPLE_W-1:0] r_y;
    logic                               r_clip;

    logic signed [bq_pkg::RND_W-1:0]    w_rnd;
    logic signed [bq_pkg::Y_W-1:0]      w_yfull;
    logic [bq_pkg::Y_W-bq_pkg::SAMPLE_W:0] w_top;
    logic                               w_ovf;

    // Round to nearest, ties upward
    assign w_rnd   = bq_pkg::RND_W'(r_acc) + HALF;
    assign w_yfull = bq_pkg::Y_W'(w_rnd >>> bq_pkg::FRAC);
    assign w_top   = w_yfull[bq_pkg::Y_W-1:bq_pkg::SAMPLE_W-1];
    assign w_ovf   = !((&w_top) || !(|w_top));

    always_ff @(posedge i_clk) begin
        if (i_step.mul_x) begin
            r_prod <= i_x * i_ff0;
        end
        if (i_step.acc) begin
            r_acc <= bq_pkg::ACC_W'(r_prod) + bq_pkg::ACC_W'(i_s0);
        end
        // Clamp for feedback; round and saturate for the output
        if (i_step.clamp) begin
            r_accf <= bq_pkg::sat_state(bq_pkg::SAT_IN_W'(r_acc));
            r_clip <= w_ovf;
            if (!w_ovf) begin
                r_y <= w_yfull[bq_pkg::SAMPLE_W-1:0];
            end else if (w_yfull[bq_pkg::Y_W-1]) begin
                r_y <= bq_pkg::SAMPLE_MIN;
            end else begin
                r_y <= bq_pkg::SAMPLE_MAX;
            end
        end
    end

    assign o_accf = r_accf;
    assign o_y    = r_y;
    assign o_clip = r_clip;

endmodule

// ===== hdl/biquad_iir_filter_top.sv =====
// ------------------------------------------------------------------------
// Biquad IIR filter, transposed direct form II
// Each sample steps through states MUL_X to UPD, holding in UPD while the
//   output register is full and stalled; a new sample is taken only in IDLE.
//   Each delay cell's single multiplier steps through x, low and high halves.
// Reset (synchronous, active low) clears the delay state, loads unity gain
//   into feed_forward_0, zeros the other coefficients and empties the output.
// ------------------------------------------------------------------------
`include "biquad_iir_filter_top_macros.svh"

module biquad_iir_filter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [bq_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bq_pkg::COEF_W-1:0]           i_cfg_data,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [bq_pkg::SAMPLE_W-1:0]  i_sample_in,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [bq_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                o_clipped
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_X,
        S_ACC,
        S_CLAMP,
        S_MUL_LO,
        S_MUL_HI,
        S_RND,
        S_UPD
    } t_fsm;

    t_fsm                              r_fsm;
    logic                              r_out_valid;
    logic signed [bq_pkg::SAMPLE_W-1:0] r_sample_out;
    logic                              r_clipped;
    logic signed [bq_pkg::SAMPLE_W-1:0] r_x;

    logic signed [bq_pkg::COEF_W-1:0]  r_ff0;
    logic signed [bq_pkg::COEF_W-1:0]  r_ff [1:bq_pkg::MAX_TAP];
    logic signed [bq_pkg::COEF_W-1:0]  r_fb [1:bq_pkg::MAX_TAP];

    bq_pkg::t_step                     w_step;
    logic                              w_accept;
    logic                              w_out_free;
    logic signed [bq_pkg::STATE_W-1:0] w_accf;
    logic signed [bq_pkg::SAMPLE_W-1:0] w_y;
    logic                              w_clip;
    logic signed [bq_pkg::STATE_W-1:0] w_state [0:bq_pkg::ORDER-1];
    logic signed [bq_pkg::STATE_W-1:0] w_next  [0:bq_pkg::ORDER-1];
    logic signed [bq_pkg::COEF_W-1:0]  w_ff    [0:bq_pkg::ORDER-1];
    logic signed [bq_pkg::COEF_W-1:0]  w_fb    [0:bq_pkg::ORDER-1];

    // Handshake
    assign o_in_stall = (r_fsm != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Decode step strobes; hold the state update until the output is free
    always_comb begin
        w_step        = '0;
        w_step.mul_x  = (r_fsm == S_MUL_X);
        w_step.acc    = (r_fsm == S_ACC);
        w_step.clamp  = (r_fsm == S_CLAMP);
        w_step.mul_lo = (r_fsm == S_MUL_LO);
        w_step.mul_hi = (r_fsm == S_MUL_HI);
        w_step.rnd    = (r_fsm == S_RND);
        w_step.upd    = (r_fsm == S_UPD) && w_out_free;
    end

    // Coefficient registers; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff0 <= bq_pkg::FF0_RESET;
            for (int k = 1; k <= bq_pkg::MAX_TAP; k++) begin
                r_ff[k] <= '0;
                r_fb[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bq_pkg::CFG_FF0: r_ff0   <= $signed(i_cfg_data);
                bq_pkg::CFG_FF1: r_ff[1] <= $signed(i_cfg_data);
                bq_pkg::CFG_FF2: r_ff[2] <= $signed(i_cfg_data);
                bq_pkg::CFG_FB1: r_fb[1] <= $signed(i_cfg_data);
                bq_pkg::CFG_FB2: r_fb[2] <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Capture the input sample on transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_sample_in;
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_fsm)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_fsm <= S_MUL_X;
                    end
                end
                S_MUL_X:  r_fsm <= S_ACC;
                S_ACC:    r_fsm <= S_CLAMP;
                S_CLAMP:  r_fsm <= S_MUL_LO;
                S_MUL_LO: r_fsm <= S_MUL_HI;
                S_MUL_HI: r_fsm <= S_RND;
                S_RND:    r_fsm <= S_UPD;
                S_UPD: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_sample_out <= w_y;
                        r_clipped    <= w_clip;
                        r_fsm        <= S_IDLE;
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

    // Output stage
    bq_head u_head (
        .i_clk  (i_clk),
        .i_step (w_step),
        .i_x    (r_x),
        .i_ff0  (r_ff0),
        .i_s0   (w_state[0]),
        .o_accf (w_accf),
        .o_y    (w_y),
        .o_clip (w_clip)
    );

    // Row of delay cells, each fed by its right-hand neighbour
    for (genvar gi = 0; gi < bq_pkg::ORDER; gi++) begin : g_cell
        if (gi + 1 < bq_pkg::ORDER) begin : g_mid
            assign w_next[gi] = w_state[gi+1];
        end else begin : g_last
            assign w_next[gi] = '0;
        end

        if (gi + 1 <= bq_pkg::MAX_TAP) begin : g_coef
            assign w_ff[gi] = r_ff[gi+1];
            assign w_fb[gi] = r_fb[gi+1];
        end else begin : g_zero
            assign w_ff[gi] = '0;
            assign w_fb[gi] = '0;
        end

        bq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (w_step),
            .i_x     (r_x),
            .i_ff    (w_ff[gi]),
            .i_fb    (w_fb[gi]),
            .i_accf  (w_accf),
            .i_next  (w_next[gi]),
            .o_state (w_state[gi])
        );
    end

    // Assertions
    `BQ_ASSERT_SAME(a_out_after_upd, $rose(o_out_valid), $past(r_fsm) == S_UPD, "output raised outside update step")
    `BQ_ASSERT_NEXT(a_accept_starts, w_accept, r_fsm == S_MUL_X, "transfer did not start the sequence")
    `BQ_ASSERT_SAME(a_clip_at_limit, o_out_valid && o_clipped, (o_sample_out == bq_pkg::SAMPLE_MAX) || (o_sample_out == bq_pkg::SAMPLE_MIN), "clipped sample not at a limit")

endmodule

// ===== verif/biquad_iir_filter_top_test.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Biquad IIR filter testbench
// Loads coefficient sets through the write port, streams samples through
// the valid/stall channels with random idle bursts on both sides, and
// checks every output transfer against an in-bench fixed-point filter.
// ------------------------------------------------------------------------
module biquad_iir_filter_top_test;

    localparam int  COEF_MAX     = (1 << (bq_pkg::COEF_W - 1)) - 1;
    localparam int  COEF_MIN     = -(1 << (bq_pkg::COEF_W - 1));
    localparam int  UNITY        = 1 << bq_pkg::FRAC;
    localparam longint HALF_LSB  = longint'(1) << (bq_pkg::FRAC - 1);
    localparam int  FIRST_SPARE_IDX = int'(bq_pkg::CFG_FB2) + 1;
    localparam int  SPARE_IDX_END = 1 << bq_pkg::CFG_IDX_W;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  RANDOM_PHASES = 10;
    localparam int  PHASE_SAMPLES = 125;
    localparam int  SETTLE_CYCLES = 12;

    typedef struct packed {
        logic signed [bq_pkg::SAMPLE_W-1:0] sample;
        logic                               clipped;
    } t_filt_out;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [bq_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [bq_pkg::COEF_W-1:0]          i_cfg_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic signed [bq_pkg::SAMPLE_W-1:0] i_sample_in = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic signed [bq_pkg::SAMPLE_W-1:0] o_sample_out;
    logic                               o_clipped;

    // Filter state mirrored in the bench
    longint ff_coef[bq_pkg::ORDER+1];
    longint fb_coef[bq_pkg::ORDER+1];
    longint delay_cell[bq_pkg::ORDER];

    t_filt_out expected_out[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    bit        in_idle_on = 1'b0;
    bit        out_idle_on = 1'b0;

    biquad_iir_filter_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("biquad_iir_filter_top_test: errors");
            $finish;
        end
    end

    // Stall the output side in random bursts
    always @(posedge i_clk) begin
        if (stall_left == 0 && out_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic longint saturate(input longint v, input int w, output bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        hit = 1'b0;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic void reset_filter_model();
        foreach (ff_coef[i]) ff_coef[i] = 0;
        foreach (fb_coef[i]) fb_coef[i] = 0;
        foreach (delay_cell[i]) delay_cell[i] = 0;
        ff_coef[0] = bq_pkg::FF0_RESET;
    endfunction

    // Advance the mirrored filter by one sample and return the output transfer
    function automatic t_filt_out filter_step(input logic signed [bq_pkg::SAMPLE_W-1:0] x);
        longint    xs;
        longint    acc;
        longint    acc_fb;
        longint    carry;
        longint    y_full;
        bit        hit;
        t_filt_out res;
        xs = x;
        acc = xs * ff_coef[0] + delay_cell[0];
        // feedback sees acc held to the state width; the output does not
        acc_fb = saturate(acc, bq_pkg::STATE_W, hit);
        for (int i = 0; i < bq_pkg::ORDER; i++) begin
            carry = (i + 1 < bq_pkg::ORDER) ? delay_cell[i + 1] : 0;
            delay_cell[i] = saturate(xs * ff_coef[i + 1]
                - ((fb_coef[i + 1] * acc_fb + HALF_LSB) >>> bq_pkg::FRAC) + carry,
                bq_pkg::STATE_W, hit);
        end
        // round half up, then clip to the sample range
        y_full = (acc + HALF_LSB) >>> bq_pkg::FRAC;
        res.sample = bq_pkg::SAMPLE_W'(saturate(y_full, bq_pkg::SAMPLE_W, hit));
        res.clipped = hit;
        return res;
    endfunction

    // Compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin : out_check
        t_filt_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_out.size() == 0) begin
                note_error($sformatf("unexpected output sample %0d clipped %0b",
                    o_sample_out, o_clipped));
            end else begin
                want = expected_out.pop_front();
                if (o_sample_out !== want.sample || o_clipped !== want.clipped) begin
                    note_error($sformatf("expected sample %0d clipped %0b, got %0d clipped %0b",
                        want.sample, want.clipped, o_sample_out, o_clipped));
                end
            end
        end
    end

    // Hold the write enable high; the caller drops it after the last write
    task automatic cfg_write(input logic [bq_pkg::CFG_IDX_W-1:0] idx, input int value);
        logic signed [bq_pkg::COEF_W-1:0] c;
        c = bq_pkg::COEF_W'(value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= c;
        @(posedge i_clk);
        case (idx)
            bq_pkg::CFG_FF0: ff_coef[0] = c;
            bq_pkg::CFG_FF1: ff_coef[1] = c;
            bq_pkg::CFG_FF2: ff_coef[2] = c;
            bq_pkg::CFG_FB1: fb_coef[1] = c;
            bq_pkg::CFG_FB2: fb_coef[2] = c;
            default: ;
        endcase
    endtask

    task automatic load_coefs(input int a0, input int a1, input int a2,
                              input int b1, input int b2);
        cfg_write(bq_pkg::CFG_FF0, a0);
        cfg_write(bq_pkg::CFG_FF1, a1);
        cfg_write(bq_pkg::CFG_FF2, a2);
        cfg_write(bq_pkg::CFG_FB1, b1);
        cfg_write(bq_pkg::CFG_FB2, b2);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one sample, hold it until the transfer, then record the prediction
    task automatic send_sample(input logic signed [bq_pkg::SAMPLE_W-1:0] x);
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_in <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_out.push_back(filter_step(x));
    endtask

    // Drop valid and wait until every expected output has gone
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic signed [bq_pkg::SAMPLE_W-1:0] rand_sample();
        logic signed [bq_pkg::SAMPLE_W-1:0] s;
        case ($urandom_range(0, 5))
            0: s = $urandom_range(0, 1) ? bq_pkg::SAMPLE_MAX : bq_pkg::SAMPLE_MIN;
            1: s = bq_pkg::SAMPLE_W'(rand_between(-256, 255));
            default: s = bq_pkg::SAMPLE_W'($urandom());
        endcase
        return s;
    endfunction

    function automatic int rand_extreme_coef();
        case ($urandom_range(0, 4))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return 0;
            3: return UNITY;
            default: return -UNITY;
        endcase
    endfunction

    // Unity gain after reset: the output follows the input
    task automatic test_reset_passthrough();
        send_sample(0);
        send_sample(1);
        send_sample(-1);
        send_sample(bq_pkg::SAMPLE_MAX);
        send_sample(bq_pkg::SAMPLE_MIN);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        drain();
    endtask

    // Half gain puts odd samples exactly on a rounding tie
    task automatic test_rounding_ties();
        load_coefs(UNITY / 2, 0, 0, 0, 0);
        send_sample(1);
        send_sample(-1);
        send_sample(3);
        send_sample(-3);
        drain();
    endtask

    // Extreme coefficients drive both the output and the delay cells into saturation
    task automatic test_coef_extremes();
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        send_sample(bq_pkg::SAMPLE_MAX);
        send_sample(bq_pkg::SAMPLE_MAX);
        send_sample(bq_pkg::SAMPLE_MIN);
        send_sample(bq_pkg::SAMPLE_MAX);
        drain();
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        send_sample(bq_pkg::SAMPLE_MIN);
        send_sample(bq_pkg::SAMPLE_MAX);
        send_sample(bq_pkg::SAMPLE_MIN);
        send_sample(0);
        drain();
    endtask

    // Writes to indexes past the register map must change nothing
    task automatic test_spare_indexes();
        load_coefs(UNITY, 0, 0, 0, 0);
        for (int idx = FIRST_SPARE_IDX; idx < SPARE_IDX_END; idx++) begin
            cfg_write(bq_pkg::CFG_IDX_W'(idx), $urandom());
        end
        i_cfg_we <= 1'b0;
        send_sample(bq_pkg::SAMPLE_MAX);
        send_sample(-1234);
        send_sample(bq_pkg::SAMPLE_MIN);
        drain();
    endtask

    // Random coefficient sets, mostly stable, with random samples
    task automatic test_random_streams();
        int b2;
        int lim;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // no idling in the closing phases
            in_idle_on = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            out_idle_on = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            case (ph % 5)
                2: load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                4: load_coefs(rand_extreme_coef(), rand_extreme_coef(), rand_extreme_coef(),
                              rand_extreme_coef(), rand_extreme_coef());
                default: begin
                    // poles inside the unit circle
                    b2 = rand_between(-24000, 30000);
                    lim = UNITY + b2 - 1;
                    load_coefs(rand_between(-UNITY / 2, UNITY / 2),
                               rand_between(-UNITY / 2, UNITY / 2),
                               rand_between(-UNITY / 2, UNITY / 2),
                               rand_between(-lim, lim), b2);
                end
            endcase
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                send_sample(rand_sample());
            end
            drain();
        end
    endtask

    initial begin
        reset_filter_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_passthrough();
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        test_rounding_ties();
        test_coef_extremes();
        test_spare_indexes();
        test_random_streams();
        if (error_count == 0) begin
            $display("biquad_iir_filter_top_test: clean");
        end else begin
            $display("biquad_iir_filter_top_test: errors");
        end
        $finish;
    end

endmodule

// ===== biquad_iir_filter_top.f =====
+incdir+hdl
hdl/bq_pkg.sv
hdl/bq_cell.sv
hdl/bq_head.sv
hdl/biquad_iir_filter_top.sv
verif/biquad_iir_filter_top_test.sv
